// File: design/spce_pkg.sv
// shared types, constants and sine table for the spectrum phase cost engine
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package spce_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_DEPTH      = 1024;
    localparam int LOG_DEPTH       = $clog2(SINE_DEPTH);
    localparam int QUARTER         = SINE_DEPTH / 4;
    localparam int TURN_UNITS      = 23040;
    localparam int THR_MULT        = 3;
    localparam int ROUND_HALF      = 8192;
    localparam int ROT_SHIFT       = 14;
    localparam int COST_FRAC       = 8;

    localparam logic [12:0] CNT_RESET = 13'd4096;
    localparam logic [47:0] COST_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic        [11:0] sample_index;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic signed [15:0] phase0_deg;
        logic signed [15:0] phase1_deg;
    } t_in_word;

    typedef struct packed {
        logic [47:0] cost;
        logic [17:0] noise_rms;
    } t_out_word;

    typedef logic signed [15:0] t_qsine [0:QUARTER];

    // quarter wave, q14, from a q30 taylor series
    function automatic t_qsine build_qsine();
        t_qsine             tab;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint             sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'd2 * PI_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = 16'((sum * 16384 + (64'sd1 <<< 29)) >>> 30);
        end
        return tab;
    endfunction

    localparam t_qsine QSINE = build_qsine();

    // full-wave sine by mirroring the quarter table
    function automatic logic signed [15:0] sine_at(input logic [LOG_DEPTH-1:0] idx);
        logic [1:0]           quad;
        logic [LOG_DEPTH-2:0] off;
        logic [LOG_DEPTH-2:0] mir;
        logic signed [15:0]   val;
        quad = idx[LOG_DEPTH-1:LOG_DEPTH-2];
        off  = {1'b0, idx[LOG_DEPTH-3:0]};
        mir  = (LOG_DEPTH-1)'(QUARTER) - off;
        case (quad)
            2'd0:    val = QSINE[off];
            2'd1:    val = QSINE[mir];
            2'd2:    val = -QSINE[off];
            default: val = -QSINE[mir];
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: design/spectrum_phase_cost_engine_top.sv
// spectrum phase cost engine: sample store, rotation pass, threshold pass
// uses spce_pkg for word types, constants and the sine table
`timescale 1ns / 1ps
`default_nettype none

// load word: written straight into the sample store
// evaluate word: the time to result valid is set by
//   one read port per store (one sample per cycle in each pass) and the
//   one-bit-per-cycle divider used four times (two for angle setup, mean square, cost)
// input stall is high from an evaluate until its result enters the output register
// synchronous active-low reset clears control and sample_count (4096); stores are not cleared

module spectrum_phase_cost_engine_top #(
    parameter int MAX_SAMPLES = spce_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire spce_pkg::t_in_word  i_in_word,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output spce_pkg::t_out_word      o_out_word,
    input  wire logic                i_cfg_we,
    input  wire logic [12:0]         i_cfg_data
);

    // widths
    localparam int AW   = $clog2(MAX_SAMPLES);       // store address
    localparam int CW   = $clog2(MAX_SAMPLES + 1);   // sample count
    localparam int TW   = 15 + CW;                   // one turn, 23040*N
    localparam int IW   = spce_pkg::LOG_DEPTH;       // sine index
    localparam int SB   = spce_pkg::SAMPLE_BITS;
    localparam int PW   = SB + 16;                   // rotation products
    localparam int YW   = 19;                        // rotated value / difference
    localparam int SQW  = 38;                        // mean square / root
    localparam int SSW  = 37 + AW;                   // sum of squares
    localparam int RW   = 20 + AW;                   // running sum
    localparam int TOTW = 20 + 2 * AW;               // sum of running sums
    localparam int DVW  = (27 + 2 * AW > 37 + AW) ? 27 + 2 * AW : 37 + AW;
    localparam int QXW  = (DVW > 48) ? DVW : 48;
    localparam int DCW  = $clog2(DVW + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TURN  = 4'd1;
    localparam logic [3:0] S_ANG0  = 4'd2;
    localparam logic [3:0] S_ANG0W = 4'd3;
    localparam logic [3:0] S_ANG1W = 4'd4;
    localparam logic [3:0] S_PASS1 = 4'd5;
    localparam logic [3:0] S_MSQW  = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_PASS2 = 4'd8;
    localparam logic [3:0] S_COSTW = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // control
    logic [3:0]    r_state;
    logic [12:0]   r_count;
    logic          r_o_valid;
    logic [CW-1:0] r_i;
    logic [AW-1:0] r_wa;
    logic          r_have_prev;
    logic          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic          r_u1, r_u2, r_u3;

    // evaluate operands
    logic signed [15:0] r_p0, r_p1;
    logic [CW-1:0]      r_n, r_nm1;
    logic [TW-1:0]      r_turn;
    logic [14:0]        r_p0m;

    // incremental angle: am*D = q*turn + r
    logic [IW-1:0] r_q, r_qp;
    logic [TW-1:0] r_r, r_rp;

    // stores
    logic [2*SB-1:0]      r_smem [0:MAX_SAMPLES-1];
    logic signed [YW-1:0] r_dmem [0:MAX_SAMPLES-1];
    logic [2*SB-1:0]      r_smp;
    logic signed [YW-1:0] r_dd;

    // rotation pass datapath
    logic signed [15:0]     r_s, r_c;
    logic signed [PW-1:0]   r_pa, r_pb;
    logic signed [YW-1:0]   r_y, r_prev, r_d;
    logic [2*YW-2:0]        r_sq;
    logic [SSW-1:0]         r_sumsq;

    // root
    logic [SQW-1:0] r_sq_val, r_sq_res, r_sq_bit;
    logic [18:0]    r_rms;
    logic [20:0]    r_thr;

    // threshold pass datapath
    logic signed [20:0]     r_v;
    logic signed [RW-1:0]   r_run;
    logic signed [TOTW-1:0] r_total;

    // divider
    logic [DVW-1:0] r_dv_num;
    logic [TW-1:0]  r_dv_rem, r_dv_den;
    logic [DCW-1:0] r_dv_cnt;
    logic           r_dv_busy, r_dv_done;

    spce_pkg::t_out_word r_out;

    // ------------------------------------------------------------------
    // combinational
    // ------------------------------------------------------------------
    logic                 in_acc, ld_we, eval_acc, iss1, iss2, end1, end2;
    logic [CW-1:0]        w_nclamp;
    logic signed [17:0]   w_p0s;
    logic [16:0]          w_p0u;
    logic [14:0]          w_p0m;
    logic [TW-1:0]        w_p1m;
    logic [15+CW-1:0]     w_am0;
    logic [TW-1:0]        w_half;
    logic [IW-1:0]        w_idx;
    logic [TW:0]          w_rsum;
    logic                 w_rwrap;
    logic signed [PW+1:0] w_rot;
    logic signed [YW-1:0] w_d;
    logic signed [2*YW-1:0] w_sq;
    logic signed [20:0]   w_d21, w_t21, w_vth;
    logic [TOTW-1:0]      w_mag;
    logic [QXW-1:0]       w_qx;
    logic [47:0]          w_cost;
    logic [SQW-1:0]       w_sq_try;
    logic                 dv_start;
    logic [DVW-1:0]       dv_num_in;
    logic [TW-1:0]        dv_den_in;
    logic [TW:0]          dv_sh, dv_sub;
    logic                 dv_ge;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_out_word = r_out;

    assign in_acc   = i_valid && !o_stall;
    assign ld_we    = in_acc && (i_in_word.req_type == spce_pkg::REQ_LOAD)
                      && (int'(i_in_word.sample_index) < MAX_SAMPLES);
    assign eval_acc = in_acc && (i_in_word.req_type == spce_pkg::REQ_EVAL);

    // issue one store read per cycle in each pass
    assign iss1 = (r_state == S_PASS1) && (r_i < r_n);
    assign iss2 = (r_state == S_PASS2) && (r_i < r_nm1);
    assign end1 = (r_state == S_PASS1) && (r_i == r_n)
                  && !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5);
    assign end2 = (r_state == S_PASS2) && (r_i == r_nm1) && !(r_u1 || r_u2 || r_u3);

    always_comb begin
        if (r_count < 13'd2) begin
            w_nclamp = CW'(2);
        end else if (int'(r_count) > MAX_SAMPLES) begin
            w_nclamp = CW'(MAX_SAMPLES);
        end else begin
            w_nclamp = CW'(r_count);
        end
    end

    // p0 modulo one turn of 23040 units
    always_comb begin
        w_p0s = 18'(r_p0) + 18'sd46080;
        w_p0u = 17'(w_p0s);
        if (w_p0u >= 17'(3 * spce_pkg::TURN_UNITS)) begin
            w_p0m = 15'(w_p0u - 17'(3 * spce_pkg::TURN_UNITS));
        end else if (w_p0u >= 17'(2 * spce_pkg::TURN_UNITS)) begin
            w_p0m = 15'(w_p0u - 17'(2 * spce_pkg::TURN_UNITS));
        end else if (w_p0u >= 17'(spce_pkg::TURN_UNITS)) begin
            w_p0m = 15'(w_p0u - 17'(spce_pkg::TURN_UNITS));
        end else begin
            w_p0m = 15'(w_p0u);
        end
    end

    // a turn is at least 46080 units, so one add brings p1 into range
    assign w_p1m = r_p1[15] ? (r_turn - TW'(-(32'(r_p1)))) : TW'(r_p1);
    assign w_am0 = (15 + CW)'(r_p0m) * (15 + CW)'(r_n);

    // rounded table index and its step
    assign w_half  = r_turn >> 1;
    assign w_idx   = r_q + IW'(r_r >= w_half);
    assign w_rsum  = {1'b0, r_r} + {1'b0, r_rp};
    assign w_rwrap = (w_rsum >= {1'b0, r_turn});

    assign w_rot = (PW + 2)'(r_pa) - (PW + 2)'(r_pb) + (PW + 2)'(spce_pkg::ROUND_HALF);
    assign w_d   = r_y - r_prev;
    assign w_sq  = r_d * r_d;

    // soft threshold
    always_comb begin
        w_d21 = 21'(r_dd);
        w_t21 = $signed(r_thr);
        if (w_d21 > w_t21) begin
            w_vth = w_d21 - w_t21;
        end else if (w_d21 < -w_t21) begin
            w_vth = w_d21 + w_t21;
        end else begin
            w_vth = '0;
        end
    end

    assign w_mag  = r_total[TOTW-1] ? TOTW'(-r_total) : TOTW'(r_total);
    assign w_qx   = QXW'(r_dv_num);
    assign w_cost = (w_qx > QXW'(spce_pkg::COST_MAX)) ? spce_pkg::COST_MAX : w_qx[47:0];

    assign w_sq_try = r_sq_res + r_sq_bit;

    // divider launches
    always_comb begin
        dv_start  = 1'b0;
        dv_num_in = '0;
        dv_den_in = r_turn;
        case (r_state)
            S_ANG0: begin
                dv_start  = 1'b1;
                dv_num_in = DVW'(w_am0) << IW;
            end
            S_ANG0W: begin
                dv_start  = r_dv_done;
                dv_num_in = DVW'(w_p1m) << IW;
            end
            S_PASS1: begin
                dv_start  = end1;
                dv_num_in = DVW'(r_sumsq);
                dv_den_in = TW'(r_nm1);
            end
            S_PASS2: begin
                dv_start  = end2;
                dv_num_in = DVW'(w_mag) << spce_pkg::COST_FRAC;
                dv_den_in = TW'(r_nm1);
            end
            default: begin
                dv_start  = 1'b0;
            end
        endcase
    end

    assign dv_sh  = {r_dv_rem, r_dv_num[DVW-1]};
    assign dv_ge  = (dv_sh >= {1'b0, r_dv_den});
    assign dv_sub = dv_sh - {1'b0, r_dv_den};

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_cnt  <= '0;
        end else begin
            r_dv_done <= 1'b0;
            if (dv_start) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt  <= DCW'(DVW);
            end else if (r_dv_busy) begin
                r_dv_cnt <= r_dv_cnt - 1'b1;
                if (r_dv_cnt == DCW'(1)) begin
                    r_dv_busy <= 1'b0;
                    r_dv_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dv_num <= dv_num_in;
            r_dv_den <= dv_den_in;
            r_dv_rem <= '0;
        end else if (r_dv_busy) begin
            r_dv_num <= {r_dv_num[DVW-2:0], dv_ge};
            r_dv_rem <= dv_ge ? dv_sub[TW-1:0] : dv_sh[TW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stores: one write and one registered read per cycle each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            r_smem[AW'(i_in_word.sample_index)] <= {i_in_word.sample_re, i_in_word.sample_im};
        end
        r_smp <= r_smem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && r_have_prev) begin
            r_dmem[r_wa] <= w_d;
        end
        r_dd <= r_dmem[r_i[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // sequencer and pipeline valids
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= spce_pkg::CNT_RESET;
            r_o_valid   <= 1'b0;
            r_i         <= '0;
            r_wa        <= '0;
            r_have_prev <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_u1        <= 1'b0;
            r_u2        <= 1'b0;
            r_u3        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            // rotation pass valids
            r_v1 <= iss1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3 && r_have_prev;
            r_v5 <= r_v4;
            if (r_v3) begin
                r_have_prev <= 1'b1;
                if (r_have_prev) begin
                    r_wa <= r_wa + 1'b1;
                end
            end

            // threshold pass valids
            r_u1 <= iss2;
            r_u2 <= r_u1;
            r_u3 <= r_u2;

            if (iss1 || iss2) begin
                r_i <= r_i + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (eval_acc) begin
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    r_state <= S_ANG0;
                end
                S_ANG0: begin
                    r_state <= S_ANG0W;
                end
                S_ANG0W: begin
                    if (r_dv_done) begin
                        r_state <= S_ANG1W;
                    end
                end
                S_ANG1W: begin
                    if (r_dv_done) begin
                        r_i         <= '0;
                        r_wa        <= '0;
                        r_have_prev <= 1'b0;
                        r_state     <= S_PASS1;
                    end
                end
                S_PASS1: begin
                    if (end1) begin
                        r_state <= S_MSQW;
                    end
                end
                S_MSQW: begin
                    if (r_dv_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_i     <= '0;
                        r_state <= S_PASS2;
                    end
                end
                S_PASS2: begin
                    if (end2) begin
                        r_state <= S_COSTW;
                    end
                end
                S_COSTW: begin
                    if (r_dv_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for the output register to be free
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (eval_acc) begin
            r_p0  <= i_in_word.phase0_deg;
            r_p1  <= i_in_word.phase1_deg;
            r_n   <= w_nclamp;
            r_nm1 <= w_nclamp - 1'b1;
        end
        if (r_state == S_TURN) begin
            r_turn <= TW'(spce_pkg::TURN_UNITS) * TW'(r_n);
            r_p0m  <= w_p0m;
        end
        if (r_state == S_ANG0W && r_dv_done) begin
            r_q <= r_dv_num[IW-1:0];
            r_r <= r_dv_rem;
        end
        if (r_state == S_ANG1W && r_dv_done) begin
            r_qp    <= r_dv_num[IW-1:0];
            r_rp    <= r_dv_rem;
            r_sumsq <= '0;
        end

        // issue stage: table lookup and angle step
        if (iss1) begin
            r_s <= spce_pkg::sine_at(w_idx);
            r_c <= spce_pkg::sine_at(w_idx + IW'(spce_pkg::QUARTER));
            r_q <= r_q + r_qp + IW'(w_rwrap);
            r_r <= w_rwrap ? TW'(w_rsum - {1'b0, r_turn}) : TW'(w_rsum);
        end
        // rotate and keep the real part
        r_pa <= $signed(r_smp[2*SB-1:SB]) * r_c;
        r_pb <= $signed(r_smp[SB-1:0]) * r_s;
        r_y  <= YW'(w_rot >>> spce_pkg::ROT_SHIFT);
        if (r_v3) begin
            r_prev <= r_y;
            r_d    <= w_d;
        end
        r_sq <= (2 * YW - 1)'(w_sq);
        if (r_v5) begin
            r_sumsq <= r_sumsq + SSW'(r_sq);
        end

        // integer square root by trial subtraction
        if (r_state == S_MSQW && r_dv_done) begin
            r_sq_val <= r_dv_num[SQW-1:0];
            r_sq_res <= '0;
            r_sq_bit <= SQW'(1) << (SQW - 2);
        end else if (r_state == S_SQRT) begin
            if (r_sq_bit == '0) begin
                r_rms   <= 19'(r_sq_res);
                r_thr   <= 21'(r_sq_res) * 21'(spce_pkg::THR_MULT);
                r_run   <= '0;
                r_total <= '0;
            end else begin
                if (r_sq_val >= w_sq_try) begin
                    r_sq_val <= r_sq_val - w_sq_try;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
        end

        // threshold, integrate, accumulate
        r_v <= w_vth;
        if (r_u2) begin
            r_run <= r_run + RW'(r_v);
        end
        if (r_u3) begin
            r_total <= r_total + TOTW'(r_run);
        end

        // quotient and root stay put until the output register takes them
        if (r_state == S_OUT && (!r_o_valid || !i_stall)) begin
            r_out.cost      <= w_cost;
            r_out.noise_rms <= r_rms[17:0];
        end
    end

endmodule

`default_nettype wire

// File: design/spce_checker.sv
// port-level checks for the spectrum phase cost engine, bound to the top level
// uses spce_pkg for the word types
`timescale 1ns / 1ps
`default_nettype none

module spce_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire spce_pkg::t_in_word  i_in_word,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire spce_pkg::t_out_word o_out_word,
    input wire logic                i_cfg_we,
    input wire logic [12:0]         i_cfg_data
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // an evaluate word makes the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_in_word.req_type == spce_pkg::REQ_EVAL) |=> o_stall)
        else $error("evaluate word did not make the block busy");

    // a load word never produces a result word
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_in_word.req_type == spce_pkg::REQ_LOAD) && !o_valid
        |=> !o_valid)
        else $error("load word produced a result word");

    // a new result word only appears at the end of a busy evaluation
    a_rise_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word without an evaluation");

endmodule

bind spectrum_phase_cost_engine_top spce_checker u_spce_checker (.*);

`default_nettype wire
